FILE: hdl/bcdld_pkg.sv
`default_nettype none

package bcdld_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned StateW  = 3;
    localparam int unsigned EventW  = 2;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned InDataW  = 40;  // 1 + 32 bits, padded to bytes
    localparam int unsigned OutDataW = 8;   // 2 + 3 bits, padded to bytes

    localparam logic [StateW-1:0] ST_IDLE     = 3'd0;
    localparam logic [StateW-1:0] ST_DEBOUNCE = 3'd1;
    localparam logic [StateW-1:0] ST_PRESSED  = 3'd2;
    localparam logic [StateW-1:0] ST_LONG     = 3'd3;
    localparam logic [StateW-1:0] ST_WAIT_2ND = 3'd4;
    localparam logic [StateW-1:0] ST_WAIT_DBL = 3'd5;

    localparam logic [EventW-1:0] EV_NONE   = 2'd0;
    localparam logic [EventW-1:0] EV_CLICK  = 2'd1;
    localparam logic [EventW-1:0] EV_DOUBLE = 2'd2;
    localparam logic [EventW-1:0] EV_LONG   = 2'd3;

    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_LONG     = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_DOUBLE   = 2'd2;

    localparam logic [CfgW-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CfgW-1:0] LONG_RST     = 16'd1000;
    localparam logic [CfgW-1:0] DOUBLE_RST   = 16'd300;

    typedef struct packed {
        logic [CfgW-1:0] debounce_ms;
        logic [CfgW-1:0] long_press_ms;
        logic [CfgW-1:0] double_click_ms;
    } cfg_t;

    typedef struct packed {
        logic [StateW-1:0] fsm_state;
        logic [EventW-1:0] event_res;
    } res_t;

endpackage

`default_nettype wire

FILE: hdl/bcdld_core.sv
`default_nettype none

module bcdld_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic                        button_level,
    input  wire logic [bcdld_pkg::TimeW-1:0] now_ms,
    input  wire bcdld_pkg::cfg_t             cfg,
    output bcdld_pkg::res_t                  res
);

    logic [bcdld_pkg::StateW-1:0] state_reg, state_next;
    logic [bcdld_pkg::TimeW-1:0]  press_start_reg, press_start_next;
    logic [bcdld_pkg::TimeW-1:0]  release_start_reg, release_start_next;
    logic                         second_press_reg, second_press_next;
    logic [bcdld_pkg::EventW-1:0] ev;
    logic [bcdld_pkg::TimeW-1:0]  held, gap;
    logic                         held_deb, held_long, gap_dbl;

    assign held      = now_ms - press_start_reg;
    assign gap       = now_ms - release_start_reg;
    assign held_deb  = held >= {{(bcdld_pkg::TimeW-bcdld_pkg::CfgW){1'b0}}, cfg.debounce_ms};
    assign held_long = held >= {{(bcdld_pkg::TimeW-bcdld_pkg::CfgW){1'b0}}, cfg.long_press_ms};
    assign gap_dbl   = gap >= {{(bcdld_pkg::TimeW-bcdld_pkg::CfgW){1'b0}}, cfg.double_click_ms};

    always_comb
    begin
        state_next         = state_reg;
        press_start_next   = press_start_reg;
        release_start_next = release_start_reg;
        second_press_next  = second_press_reg;
        ev                 = bcdld_pkg::EV_NONE;
        if (!button_level)
        begin
            case (state_reg)
                bcdld_pkg::ST_DEBOUNCE:
                begin
                    if (held_deb)
                        state_next = bcdld_pkg::ST_PRESSED;
                end
                bcdld_pkg::ST_PRESSED:
                begin
                    if (held_long)
                    begin
                        state_next        = bcdld_pkg::ST_LONG;
                        second_press_next = 1'b0;
                    end
                end
                bcdld_pkg::ST_WAIT_2ND:
                begin
                    press_start_next  = now_ms;
                    state_next        = bcdld_pkg::ST_DEBOUNCE;
                    second_press_next = 1'b1;
                end
                bcdld_pkg::ST_LONG, bcdld_pkg::ST_WAIT_DBL:
                begin
                end
                default:
                begin
                    press_start_next  = now_ms;
                    state_next        = bcdld_pkg::ST_DEBOUNCE;
                    second_press_next = 1'b0;
                end
            endcase
        end
        else
        begin
            case (state_reg)
                bcdld_pkg::ST_DEBOUNCE:
                    state_next = bcdld_pkg::ST_IDLE;
                bcdld_pkg::ST_PRESSED:
                begin
                    state_next = second_press_reg ? bcdld_pkg::ST_WAIT_DBL
                                                  : bcdld_pkg::ST_WAIT_2ND;
                    release_start_next = now_ms;
                end
                bcdld_pkg::ST_LONG:
                begin
                    state_next        = bcdld_pkg::ST_IDLE;
                    second_press_next = 1'b0;
                    ev                = bcdld_pkg::EV_LONG;
                end
                bcdld_pkg::ST_WAIT_2ND:
                begin
                    if (gap_dbl)
                    begin
                        state_next = bcdld_pkg::ST_IDLE;
                        ev         = bcdld_pkg::EV_CLICK;
                    end
                end
                bcdld_pkg::ST_WAIT_DBL:
                begin
                    state_next        = bcdld_pkg::ST_IDLE;
                    second_press_next = 1'b0;
                    ev                = bcdld_pkg::EV_DOUBLE;
                end
                default:
                    state_next = bcdld_pkg::ST_IDLE;
            endcase
        end
    end

    assign res.event_res = ev;
    assign res.fsm_state = state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= bcdld_pkg::ST_IDLE;
            press_start_reg   <= '0;
            release_start_reg <= '0;
            second_press_reg  <= 1'b0;
        end
        else if (step)
        begin
            state_reg         <= state_next;
            press_start_reg   <= press_start_next;
            release_start_reg <= release_start_next;
            second_press_reg  <= second_press_next;
        end
    end

    state_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= bcdld_pkg::ST_WAIT_DBL)
        else $error("state code out of range");

    second_only_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
        step && $rose(second_press_reg) |-> $past(state_reg) == bcdld_pkg::ST_WAIT_2ND)
        else $error("second press flag set outside wait state");

    no_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(state_reg) && $stable(press_start_reg))
        else $error("state moved without a request");

endmodule

`default_nettype wire

FILE: hdl/button_click_double_long_detector.sv
`default_nettype none

// Channel     Dir  Handshake                  Payload
// s_axis      in   s_axis_tvalid/tready       tdata: button_level, now_ms
// m_axis      out  m_axis_tvalid/tready       tdata: event_res, fsm_state
// cfg         in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One request per cycle while s_axis_tready is high; its result is registered in the
// output register, or in the skid register while m_axis stalls. The state update is a
// 32-bit subtract and compare feeding the result register. A skid register holds one
// extra result, so s_axis_tready drops only after m_axis stalls with two results held.
// Reset restores idle state and the default timing registers.

module button_click_double_long_detector (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [bcdld_pkg::InDataW-1:0]    s_axis_tdata,  // [0] button_level, [32:1] now_ms
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [bcdld_pkg::OutDataW-1:0]   m_axis_tdata,  // [1:0] event_res, [4:2] fsm_state
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bcdld_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [bcdld_pkg::CfgW-1:0]       cfg_data
);

    bcdld_pkg::cfg_t cfg_reg;
    bcdld_pkg::res_t res, out_reg, skid_reg;
    logic            out_valid_reg, skid_valid_reg;
    logic            in_acc, out_acc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= bcdld_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ms   <= bcdld_pkg::LONG_RST;
            cfg_reg.double_click_ms <= bcdld_pkg::DOUBLE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bcdld_pkg::REG_DEBOUNCE: cfg_reg.debounce_ms     <= cfg_data;
                bcdld_pkg::REG_LONG:     cfg_reg.long_press_ms   <= cfg_data;
                bcdld_pkg::REG_DOUBLE:   cfg_reg.double_click_ms <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign in_acc        = s_axis_tvalid && !skid_valid_reg;
    assign out_acc       = out_valid_reg && m_axis_tready;

    bcdld_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_acc),
        .button_level (s_axis_tdata[0]),
        .now_ms       (s_axis_tdata[bcdld_pkg::TimeW:1]),
        .cfg          (cfg_reg),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_acc)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_acc)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (!out_valid_reg || out_acc)
                out_reg <= res;
            else
                skid_reg <= res;
        end
        else if (out_acc && skid_valid_reg)
            out_reg <= skid_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(bcdld_pkg::OutDataW-bcdld_pkg::StateW-bcdld_pkg::EventW){1'b0}},
                            out_reg.fsm_state, out_reg.event_res};

    skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output is empty");

    accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    event_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.event_res != bcdld_pkg::EV_NONE
            |-> out_reg.fsm_state == bcdld_pkg::ST_IDLE)
        else $error("event reported outside idle");

endmodule

`default_nettype wire
